FILE: hdl/rk4o_pkg.sv
// Shared types, codes and the step microprogram for the RK4 oscillator stepper.
package rk4o_pkg;

    localparam int DATA_W    = 32;
    localparam int DT_W      = 20;
    localparam int CFG_IDX_W = 3;
    localparam int PC_W      = 6;
    localparam int SCR_AW    = 4;
    localparam int SCR_DEPTH = 16;
    localparam int SRC_W     = 5;
    localparam int SRC_MEM_BIT = 4;   // set: operand lives in scratch memory

    localparam logic [PC_W-1:0] LAST_PC = 6'd49;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STIFFNESS = 3'd0,
        CFG_DAMPING   = 3'd1,
        CFG_CONST_ACC = 3'd2,
        CFG_START_POS = 3'd3,
        CFG_START_VEL = 3'd4
    } cfg_idx_t;

    typedef enum logic {
        OP_ADD = 1'b0,
        OP_MUL = 1'b1
    } op_t;

    // Operand / destination codes. Upper half maps to scratch addresses.
    typedef enum logic [SRC_W-1:0] {
        SRC_X     = 5'd0,
        SRC_V     = 5'd1,
        SRC_A     = 5'd2,
        SRC_B     = 5'd3,
        SRC_C     = 5'd4,
        SRC_DT    = 5'd5,
        SRC_HALF  = 5'd6,
        SRC_SIXTH = 5'd7,
        SRC_THIRD = 5'd8,
        SRC_KV0   = 5'd16,
        SRC_KX1   = 5'd17,
        SRC_KV1   = 5'd18,
        SRC_KX2   = 5'd19,
        SRC_KV2   = 5'd20,
        SRC_KX3   = 5'd21,
        SRC_KV3   = 5'd22,
        SRC_T0    = 5'd23,
        SRC_T1    = 5'd24,
        SRC_T2    = 5'd25,
        SRC_WX    = 5'd26,
        SRC_WV    = 5'd27
    } src_t;

    typedef struct packed {
        op_t  op;
        src_t dst;
        src_t src_a;
        src_t src_b;
    } uop_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_WB,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;     // input beat taken
        logic rd_en;     // fetch operands
        logic mul_en;    // capture product
        logic wb_en;     // write back result
        logic out_load;  // move state into output register
        uop_t uop;
    } ctl_t;

    function automatic uop_t make_uop(op_t op, src_t d, src_t a, src_t b);
        uop_t u;
        u.op    = op;
        u.dst   = d;
        u.src_a = a;
        u.src_b = b;
        return u;
    endfunction

    // One RK4 step. kx0 is the velocity itself.
    function automatic uop_t uop_rom(logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            // kv0 = acc(x, v)
            6'd0:  u = make_uop(OP_MUL, SRC_T0, SRC_A, SRC_X);
            6'd1:  u = make_uop(OP_MUL, SRC_T1, SRC_B, SRC_V);
            6'd2:  u = make_uop(OP_ADD, SRC_T0, SRC_T0, SRC_T1);
            6'd3:  u = make_uop(OP_ADD, SRC_KV0, SRC_T0, SRC_C);
            // kx1
            6'd4:  u = make_uop(OP_MUL, SRC_T0, SRC_HALF, SRC_KV0);
            6'd5:  u = make_uop(OP_MUL, SRC_T0, SRC_T0, SRC_DT);
            6'd6:  u = make_uop(OP_ADD, SRC_KX1, SRC_V, SRC_T0);
            // kv1
            6'd7:  u = make_uop(OP_MUL, SRC_T0, SRC_HALF, SRC_V);
            6'd8:  u = make_uop(OP_MUL, SRC_T0, SRC_T0, SRC_DT);
            6'd9:  u = make_uop(OP_ADD, SRC_T2, SRC_X, SRC_T0);
            6'd10: u = make_uop(OP_MUL, SRC_T0, SRC_A, SRC_T2);
            6'd11: u = make_uop(OP_MUL, SRC_T1, SRC_B, SRC_KX1);
            6'd12: u = make_uop(OP_ADD, SRC_T0, SRC_T0, SRC_T1);
            6'd13: u = make_uop(OP_ADD, SRC_KV1, SRC_T0, SRC_C);
            // kx2
            6'd14: u = make_uop(OP_MUL, SRC_T0, SRC_HALF, SRC_KV1);
            6'd15: u = make_uop(OP_MUL, SRC_T0, SRC_T0, SRC_DT);
            6'd16: u = make_uop(OP_ADD, SRC_KX2, SRC_V, SRC_T0);
            // kv2
            6'd17: u = make_uop(OP_MUL, SRC_T0, SRC_HALF, SRC_KX1);
            6'd18: u = make_uop(OP_MUL, SRC_T0, SRC_T0, SRC_DT);
            6'd19: u = make_uop(OP_ADD, SRC_T2, SRC_X, SRC_T0);
            6'd20: u = make_uop(OP_MUL, SRC_T0, SRC_A, SRC_T2);
            6'd21: u = make_uop(OP_MUL, SRC_T1, SRC_B, SRC_KX2);
            6'd22: u = make_uop(OP_ADD, SRC_T0, SRC_T0, SRC_T1);
            6'd23: u = make_uop(OP_ADD, SRC_KV2, SRC_T0, SRC_C);
            // kx3
            6'd24: u = make_uop(OP_MUL, SRC_T0, SRC_KV2, SRC_DT);
            6'd25: u = make_uop(OP_ADD, SRC_KX3, SRC_V, SRC_T0);
            // kv3
            6'd26: u = make_uop(OP_MUL, SRC_T0, SRC_KX2, SRC_DT);
            6'd27: u = make_uop(OP_ADD, SRC_T2, SRC_X, SRC_T0);
            6'd28: u = make_uop(OP_MUL, SRC_T0, SRC_A, SRC_T2);
            6'd29: u = make_uop(OP_MUL, SRC_T1, SRC_B, SRC_KX3);
            6'd30: u = make_uop(OP_ADD, SRC_T0, SRC_T0, SRC_T1);
            6'd31: u = make_uop(OP_ADD, SRC_KV3, SRC_T0, SRC_C);
            // weighted sum of position slopes
            6'd32: u = make_uop(OP_MUL, SRC_T0, SRC_SIXTH, SRC_V);
            6'd33: u = make_uop(OP_MUL, SRC_T1, SRC_THIRD, SRC_KX1);
            6'd34: u = make_uop(OP_ADD, SRC_WX, SRC_T0, SRC_T1);
            6'd35: u = make_uop(OP_MUL, SRC_T0, SRC_THIRD, SRC_KX2);
            6'd36: u = make_uop(OP_ADD, SRC_WX, SRC_WX, SRC_T0);
            6'd37: u = make_uop(OP_MUL, SRC_T0, SRC_SIXTH, SRC_KX3);
            6'd38: u = make_uop(OP_ADD, SRC_WX, SRC_WX, SRC_T0);
            // weighted sum of velocity slopes
            6'd39: u = make_uop(OP_MUL, SRC_T0, SRC_SIXTH, SRC_KV0);
            6'd40: u = make_uop(OP_MUL, SRC_T1, SRC_THIRD, SRC_KV1);
            6'd41: u = make_uop(OP_ADD, SRC_WV, SRC_T0, SRC_T1);
            6'd42: u = make_uop(OP_MUL, SRC_T0, SRC_THIRD, SRC_KV2);
            6'd43: u = make_uop(OP_ADD, SRC_WV, SRC_WV, SRC_T0);
            6'd44: u = make_uop(OP_MUL, SRC_T0, SRC_SIXTH, SRC_KV3);
            6'd45: u = make_uop(OP_ADD, SRC_WV, SRC_WV, SRC_T0);
            // state update
            6'd46: u = make_uop(OP_MUL, SRC_T0, SRC_DT, SRC_WX);
            6'd47: u = make_uop(OP_ADD, SRC_X, SRC_X, SRC_T0);
            6'd48: u = make_uop(OP_MUL, SRC_T0, SRC_DT, SRC_WV);
            6'd49: u = make_uop(OP_ADD, SRC_V, SRC_V, SRC_T0);
            default: u = make_uop(OP_ADD, SRC_T0, SRC_T0, SRC_T0);
        endcase
        return u;
    endfunction

endpackage

FILE: hdl/rk4o_scratch.sv
// Scratch register file for intermediate slopes: one write port, two registered reads.
module rk4o_scratch (
    input  logic                                aclk,
    input  logic                                wr_en,
    input  logic [rk4o_pkg::SCR_AW-1:0]         wr_addr,
    input  logic signed [rk4o_pkg::DATA_W-1:0]  wr_data,
    input  logic                                rd_en,
    input  logic [rk4o_pkg::SCR_AW-1:0]         rd_addr_a,
    input  logic [rk4o_pkg::SCR_AW-1:0]         rd_addr_b,
    output logic signed [rk4o_pkg::DATA_W-1:0]  rd_data_a,
    output logic signed [rk4o_pkg::DATA_W-1:0]  rd_data_b
);

    logic signed [rk4o_pkg::DATA_W-1:0] mem [rk4o_pkg::SCR_DEPTH];
    logic signed [rk4o_pkg::DATA_W-1:0] rd_a_reg;
    logic signed [rk4o_pkg::DATA_W-1:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

FILE: hdl/rk4o_alu.sv
// Shared arithmetic unit: registered fixed-point multiply with floor and saturation,
// and a saturating add.
module rk4o_alu #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                mul_en,
    input  rk4o_pkg::op_t                       op,
    input  logic signed [rk4o_pkg::DATA_W-1:0]  op_a,
    input  logic signed [rk4o_pkg::DATA_W-1:0]  op_b,
    output logic signed [rk4o_pkg::DATA_W-1:0]  result
);

    localparam int PROD_W = 2 * rk4o_pkg::DATA_W;
    localparam logic signed [rk4o_pkg::DATA_W-1:0] S_MAX = {1'b0, {(rk4o_pkg::DATA_W-1){1'b1}}};
    localparam logic signed [rk4o_pkg::DATA_W-1:0] S_MIN = {1'b1, {(rk4o_pkg::DATA_W-1){1'b0}}};

    logic signed [PROD_W-1:0]          prod_reg;
    logic signed [PROD_W-1:0]          prod_next;
    logic signed [PROD_W-1:0]          shifted;
    logic [PROD_W-rk4o_pkg::DATA_W:0]  top_bits;
    logic signed [rk4o_pkg::DATA_W-1:0] mul_res;
    logic signed [rk4o_pkg::DATA_W:0]  sum;
    logic signed [rk4o_pkg::DATA_W-1:0] add_res;

    assign prod_next = PROD_W'(op_a) * PROD_W'(op_b);

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= prod_next;
        end
    end

    // arithmetic shift gives floor; saturate when the upper bits are not all sign
    always_comb begin
        shifted  = prod_reg >>> FRAC_BITS;
        top_bits = shifted[PROD_W-1:rk4o_pkg::DATA_W-1];
        if ((&top_bits) || !(|top_bits)) begin
            mul_res = shifted[rk4o_pkg::DATA_W-1:0];
        end else if (shifted[PROD_W-1]) begin
            mul_res = S_MIN;
        end else begin
            mul_res = S_MAX;
        end
    end

    always_comb begin
        sum = {op_a[rk4o_pkg::DATA_W-1], op_a} + {op_b[rk4o_pkg::DATA_W-1], op_b};
        if (sum[rk4o_pkg::DATA_W] == sum[rk4o_pkg::DATA_W-1]) begin
            add_res = sum[rk4o_pkg::DATA_W-1:0];
        end else if (sum[rk4o_pkg::DATA_W]) begin
            add_res = S_MIN;
        end else begin
            add_res = S_MAX;
        end
    end

    assign result = (op == rk4o_pkg::OP_MUL) ? mul_res : add_res;

endmodule

FILE: hdl/rk4o_ctrl.sv
// Microprogram sequencer: walks the RK4 step program one operation at a time.
module rk4o_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 out_free,
    output logic                 s_ready,
    output rk4o_pkg::ctl_t       ctl
);

    rk4o_pkg::state_t              state_reg;
    rk4o_pkg::state_t              state_next;
    logic [rk4o_pkg::PC_W-1:0]     pc_reg;
    logic [rk4o_pkg::PC_W-1:0]     pc_next;
    rk4o_pkg::uop_t                uop;
    logic                          last_op;

    assign uop     = rk4o_pkg::uop_rom(pc_reg);
    assign last_op = (pc_reg == rk4o_pkg::LAST_PC);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rk4o_pkg::ST_IDLE;
            pc_reg    <= '0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rk4o_pkg::ST_IDLE: begin
                if (s_valid) state_next = rk4o_pkg::ST_READ;
            end
            rk4o_pkg::ST_READ: begin
                state_next = (uop.op == rk4o_pkg::OP_MUL) ? rk4o_pkg::ST_MUL : rk4o_pkg::ST_WB;
            end
            rk4o_pkg::ST_MUL: begin
                state_next = rk4o_pkg::ST_WB;
            end
            rk4o_pkg::ST_WB: begin
                state_next = last_op ? rk4o_pkg::ST_DONE : rk4o_pkg::ST_READ;
            end
            rk4o_pkg::ST_DONE: begin
                if (out_free) state_next = rk4o_pkg::ST_IDLE;
            end
            default: state_next = rk4o_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        pc_next = pc_reg;
        if (state_reg == rk4o_pkg::ST_IDLE) begin
            pc_next = '0;
        end else if (state_reg == rk4o_pkg::ST_WB && !last_op) begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_comb begin
        s_ready      = (state_reg == rk4o_pkg::ST_IDLE);
        ctl.start    = s_ready && s_valid;
        ctl.rd_en    = (state_reg == rk4o_pkg::ST_READ);
        ctl.mul_en   = (state_reg == rk4o_pkg::ST_MUL);
        ctl.wb_en    = (state_reg == rk4o_pkg::ST_WB);
        ctl.out_load = (state_reg == rk4o_pkg::ST_DONE) && out_free;
        ctl.uop      = uop;
    end

endmodule

FILE: hdl/rk4_linear_oscillator_step_top.sv
// Top level of the RK4 stepper for x'' = a*x + b*x' + c in signed fixed point.
//
// Each input beat advances the kept position and velocity by one classic
// fourth-order Runge-Kutta step of length s_time_step (unsigned, FRAC_BITS
// fraction bits); s_restart first reloads both from the start registers. The
// step runs as a 50-operation microprogram (28 multiplies, 22 adds) on a single
// shared multiply/add unit: a multiply passes through operand fetch, product
// register and shift/saturate write-back, an add through operand fetch and
// write-back. No new input beat is taken until the step has finished and its
// result has moved into the output register; a finished step waits while
// that register is still full. The result sits in an output register, so a
// new beat is taken while a finished result still waits for m_ready. Products
// floor and saturate to 32 bits, sums saturate. Configuration writes (index
// 0..4: stiffness, damping, constant acceleration, start position, start
// velocity) are registered; indexes beyond 4 are dropped.
module rk4_linear_oscillator_step_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration
    input  logic                                  cfg_wr_en,
    input  logic [rk4o_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rk4o_pkg::DATA_W-1:0]           cfg_wdata,
    // step input
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [rk4o_pkg::DT_W-1:0]             s_time_step,
    input  logic                                  s_restart,
    // result output
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [rk4o_pkg::DATA_W-1:0]    m_position,
    output logic signed [rk4o_pkg::DATA_W-1:0]    m_velocity
);

    localparam int W = rk4o_pkg::DATA_W;

    // fixed-point constants 0.5, 1/6, 1/3 (rounded)
    localparam longint unsigned Q_ONE = 64'd1 << FRAC_BITS;
    localparam logic signed [W-1:0] Q_HALF  = W'(Q_ONE >> 1);
    localparam logic signed [W-1:0] Q_SIXTH = W'((Q_ONE + 64'd3) / 64'd6);
    localparam logic signed [W-1:0] Q_THIRD = W'((Q_ONE + 64'd1) / 64'd3);

    // configuration registers
    logic signed [W-1:0] stiff_reg;
    logic signed [W-1:0] damp_reg;
    logic signed [W-1:0] const_reg;
    logic signed [W-1:0] start_pos_reg;
    logic signed [W-1:0] start_vel_reg;

    // kept state and the latched step length
    logic signed [W-1:0]            x_reg;
    logic signed [W-1:0]            v_reg;
    logic [rk4o_pkg::DT_W-1:0]      dt_reg;

    // operand fetch
    logic signed [W-1:0] fix_a_reg;
    logic signed [W-1:0] fix_b_reg;
    logic                a_mem_reg;
    logic                b_mem_reg;
    logic signed [W-1:0] scr_rd_a;
    logic signed [W-1:0] scr_rd_b;
    logic signed [W-1:0] op_a;
    logic signed [W-1:0] op_b;
    logic signed [W-1:0] alu_res;
    logic                scr_wr_en;

    // output register
    logic                m_valid_reg;
    logic signed [W-1:0] m_pos_reg;
    logic signed [W-1:0] m_vel_reg;
    logic                out_free;

    rk4o_pkg::ctl_t      ctl;

    assign out_free = !m_valid_reg || m_ready;

    rk4o_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .out_free (out_free),
        .s_ready  (s_ready),
        .ctl      (ctl)
    );

    // config writes; out-of-range index is ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stiff_reg     <= '0;
            damp_reg      <= '0;
            const_reg     <= '0;
            start_pos_reg <= '0;
            start_vel_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (rk4o_pkg::cfg_idx_t'(cfg_index))
                rk4o_pkg::CFG_STIFFNESS: stiff_reg     <= cfg_wdata;
                rk4o_pkg::CFG_DAMPING:   damp_reg      <= cfg_wdata;
                rk4o_pkg::CFG_CONST_ACC: const_reg     <= cfg_wdata;
                rk4o_pkg::CFG_START_POS: start_pos_reg <= cfg_wdata;
                rk4o_pkg::CFG_START_VEL: start_vel_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // state: restart load on the input beat, program write-back otherwise
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg <= '0;
            v_reg <= '0;
        end else if (ctl.start) begin
            if (s_restart) begin
                x_reg <= start_pos_reg;
                v_reg <= start_vel_reg;
            end
        end else if (ctl.wb_en) begin
            if (ctl.uop.dst == rk4o_pkg::SRC_X) x_reg <= alu_res;
            if (ctl.uop.dst == rk4o_pkg::SRC_V) v_reg <= alu_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            dt_reg <= s_time_step;
        end
    end

    // non-scratch operand select
    function automatic logic signed [W-1:0] fixed_val(rk4o_pkg::src_t s);
        logic signed [W-1:0] val;
        unique case (s)
            rk4o_pkg::SRC_X:     val = x_reg;
            rk4o_pkg::SRC_V:     val = v_reg;
            rk4o_pkg::SRC_A:     val = stiff_reg;
            rk4o_pkg::SRC_B:     val = damp_reg;
            rk4o_pkg::SRC_C:     val = const_reg;
            rk4o_pkg::SRC_DT:    val = W'(dt_reg);
            rk4o_pkg::SRC_HALF:  val = Q_HALF;
            rk4o_pkg::SRC_SIXTH: val = Q_SIXTH;
            rk4o_pkg::SRC_THIRD: val = Q_THIRD;
            default:             val = '0;
        endcase
        return val;
    endfunction

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            fix_a_reg <= fixed_val(ctl.uop.src_a);
            fix_b_reg <= fixed_val(ctl.uop.src_b);
            a_mem_reg <= ctl.uop.src_a[rk4o_pkg::SRC_MEM_BIT];
            b_mem_reg <= ctl.uop.src_b[rk4o_pkg::SRC_MEM_BIT];
        end
    end

    assign scr_wr_en = ctl.wb_en && ctl.uop.dst[rk4o_pkg::SRC_MEM_BIT];

    rk4o_scratch u_scratch (
        .aclk      (aclk),
        .wr_en     (scr_wr_en),
        .wr_addr   (ctl.uop.dst[rk4o_pkg::SCR_AW-1:0]),
        .wr_data   (alu_res),
        .rd_en     (ctl.rd_en),
        .rd_addr_a (ctl.uop.src_a[rk4o_pkg::SCR_AW-1:0]),
        .rd_addr_b (ctl.uop.src_b[rk4o_pkg::SCR_AW-1:0]),
        .rd_data_a (scr_rd_a),
        .rd_data_b (scr_rd_b)
    );

    assign op_a = a_mem_reg ? scr_rd_a : fix_a_reg;
    assign op_b = b_mem_reg ? scr_rd_b : fix_b_reg;

    rk4o_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .aclk   (aclk),
        .mul_en (ctl.mul_en),
        .op     (ctl.uop.op),
        .op_a   (op_a),
        .op_b   (op_b),
        .result (alu_res)
    );

    // result beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            m_pos_reg <= x_reg;
            m_vel_reg <= v_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_position = m_pos_reg;
    assign m_velocity = m_vel_reg;

    // a new result only appears after the program finished
    a_valid_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(ctl.out_load))
        else $error("result beat raised without a finished step");

    // multiply write-back always follows a product capture
    a_mul_wb_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.wb_en && ctl.uop.op == rk4o_pkg::OP_MUL) |-> $past(ctl.mul_en))
        else $error("multiply written back without product");

    // no input beat while the program runs
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.rd_en || ctl.mul_en || ctl.wb_en) |-> !s_ready)
        else $error("input ready during a step");

    // restart loads the start position into the state
    a_restart_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_restart) |=> (x_reg == $past(start_pos_reg)))
        else $error("restart did not load start position");

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the RK4 linear oscillator stepper.
`timescale 1ns / 100ps

module tb;
    import rk4o_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int LONG_HOLD = 600;      // cycles of receiver back-pressure
    localparam int DRAIN_LIMIT = 5000;   // end-of-run wait for stragglers
    localparam int SETTLE_CYCLES = 150;  // end-of-run settle wait
    localparam int RAND_PHASES = 25;
    localparam int PHASE_ITEMS = 50;

    typedef struct packed {
        logic signed [DATA_W-1:0] position;
        logic signed [DATA_W-1:0] velocity;
    } osc_state_t;

    // Tracks coefficients and oscillator state, predicts each step in Q16.16
    // and checks returned beats in order.
    class rk4_step_tracker;
        localparam longint S32_MAX = 64'sd2147483647;
        localparam longint S32_MIN = -S32_MAX - 1;
        localparam longint Q_ONE   = longint'(1) << FRAC_BITS;
        localparam longint Q_HALF  = longint'(1) << (FRAC_BITS - 1);
        localparam longint Q_SIXTH = (Q_ONE + 3) / 6;
        localparam longint Q_THIRD = (Q_ONE + 1) / 3;

        longint coef_pos, coef_vel, coef_const, init_pos, init_vel;
        longint cur_pos, cur_vel;
        osc_state_t expected_states[$];
        int mismatches;

        function new();
            coef_pos = 0; coef_vel = 0; coef_const = 0;
            init_pos = 0; init_vel = 0;
            cur_pos = 0; cur_vel = 0;
            mismatches = 0;
        endfunction

        function longint sat32(longint p);
            if (p > S32_MAX) return S32_MAX;
            if (p < S32_MIN) return S32_MIN;
            return p;
        endfunction

        // floor shift: >>> on a signed 64-bit product rounds toward -inf
        function longint fx_mul(longint p, longint q);
            return sat32((p * q) >>> FRAC_BITS);
        endfunction

        function longint fx_add(longint p, longint q);
            return sat32(p + q);
        endfunction

        function longint accel(longint pos, longint vel);
            return fx_add(fx_add(fx_mul(coef_pos, pos), fx_mul(coef_vel, vel)), coef_const);
        endfunction

        function longint weighted(longint k0, longint k1, longint k2, longint k3);
            longint s;
            s = fx_add(fx_mul(Q_SIXTH, k0), fx_mul(Q_THIRD, k1));
            s = fx_add(s, fx_mul(Q_THIRD, k2));
            return fx_add(s, fx_mul(Q_SIXTH, k3));
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
            longint val;
            val = longint'($signed(data));
            case (idx)
                CFG_STIFFNESS: coef_pos = val;
                CFG_DAMPING:   coef_vel = val;
                CFG_CONST_ACC: coef_const = val;
                CFG_START_POS: init_pos = val;
                CFG_START_VEL: init_vel = val;
                default: ;   // unmapped index, dropped by the block
            endcase
        endfunction

        // Accepted input beat: advance the tracked state by one RK4 step.
        function void note_step(logic [DT_W-1:0] dt_bits, logic restart);
            longint dt, x, v;
            longint kx0, kx1, kx2, kx3, kv0, kv1, kv2, kv3;
            osc_state_t nxt;
            dt = longint'(dt_bits);
            if (restart) begin
                cur_pos = init_pos;
                cur_vel = init_vel;
            end
            x = cur_pos;
            v = cur_vel;
            kx0 = v;
            kv0 = accel(x, v);
            kx1 = fx_add(v, fx_mul(fx_mul(Q_HALF, kv0), dt));
            kv1 = accel(fx_add(x, fx_mul(fx_mul(Q_HALF, kx0), dt)), kx1);
            kx2 = fx_add(v, fx_mul(fx_mul(Q_HALF, kv1), dt));
            kv2 = accel(fx_add(x, fx_mul(fx_mul(Q_HALF, kx1), dt)), kx2);
            kx3 = fx_add(v, fx_mul(kv2, dt));
            kv3 = accel(fx_add(x, fx_mul(kx2, dt)), kx3);
            cur_pos = fx_add(x, fx_mul(dt, weighted(kx0, kx1, kx2, kx3)));
            cur_vel = fx_add(v, fx_mul(dt, weighted(kv0, kv1, kv2, kv3)));
            nxt.position = cur_pos[DATA_W-1:0];
            nxt.velocity = cur_vel[DATA_W-1:0];
            expected_states.push_back(nxt);
        endfunction

        function void check_result(logic signed [DATA_W-1:0] pos, logic signed [DATA_W-1:0] vel);
            osc_state_t want;
            if (expected_states.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result beat pos=%h vel=%h", $realtime, pos, vel);
                return;
            end
            want = expected_states.pop_front();
            if (pos !== want.position || vel !== want.velocity) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result mismatch pos exp %h got %h, vel exp %h got %h",
                             $realtime, want.position, pos, want.velocity, vel);
            end
        endfunction

        function int pending();
            return expected_states.size();
        endfunction

        function bit clean();
            return mismatches == 0 && expected_states.size() == 0;
        endfunction
    endclass

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_wr_en;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [DATA_W-1:0]          cfg_wdata;
    logic                       s_valid;
    logic                       s_ready;
    logic [DT_W-1:0]            s_time_step;
    logic                       s_restart;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [DATA_W-1:0]   m_position;
    logic signed [DATA_W-1:0]   m_velocity;

    rk4_step_tracker osc_model;

    // Gap/stall enables; both go off for the tail of the run.
    bit src_gaps;
    bit snk_gaps;
    bit long_hold_req;

    rk4_linear_oscillator_step_top #(
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_time_step (s_time_step),
        .s_restart   (s_restart),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_position  (m_position),
        .m_velocity  (m_velocity)
    );

    // 2 ns clock
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Hard stop: a run that has not finished by this timeout fails.
    initial begin
        #2000000;
        $display("** rk4_linear_oscillator_step_top: FAILED **");
        $finish;
    end

    // Result monitor. Sampled at the rising edge, before the block's own
    // nonblocking updates land, so the beat seen is the one taken.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            osc_model.check_result(m_position, m_velocity);
    end

    // Receiver: ready in random bursts, random stalls, and one long hold-off
    // on request so the block backs up into its input.
    initial begin
        int n;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
            end else if (snk_gaps && $urandom_range(0, 2) == 0) begin
                n = $urandom_range(1, 19);
                m_ready <= 1'b0;
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
                if (snk_gaps)
                    repeat ($urandom_range(0, 19)) @(negedge aclk);
            end
        end
    end

    // One register write; the model follows at the edge that takes it.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        osc_model.write_reg(idx, data);
    endtask

    task automatic set_coefs(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
                             input logic [DATA_W-1:0] c, input logic [DATA_W-1:0] x0,
                             input logic [DATA_W-1:0] v0);
        cfg_write(CFG_STIFFNESS, a);
        cfg_write(CFG_DAMPING, b);
        cfg_write(CFG_CONST_ACC, c);
        cfg_write(CFG_START_POS, x0);
        cfg_write(CFG_START_VEL, v0);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one step beat, optionally after a random gap; returns once taken.
    task automatic send_step(input logic [DT_W-1:0] dt, input logic restart);
        int gap;
        @(negedge aclk);
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_time_step <= dt;
        s_restart   <= restart;
        do @(posedge aclk); while (!s_ready);
        osc_model.note_step(dt, restart);
    endtask

    // Drop valid and wait for every predicted result to come back, so the
    // block is idle before the next register write.
    task automatic drain_steps();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (osc_model.pending() != 0) @(posedge aclk);
    endtask

    // Signed Q16.16 value: mostly moderate magnitudes that keep the
    // integration meaningful, some raw noise, some range limits.
    function automatic logic [DATA_W-1:0] pick_value(input int unsigned mag);
        int unsigned r;
        logic [DATA_W-1:0] m;
        r = $urandom_range(0, 9);
        if (r < 7) begin
            m = $urandom_range(0, mag);
            return ($urandom_range(0, 1) != 0) ? -m : m;
        end
        if (r < 9)
            return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Step length: mostly short, some zero, some raw 20-bit, some corners.
    function automatic logic [DT_W-1:0] pick_step();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 13) return DT_W'($urandom_range(0, 16'h2000));
        if (r < 15) return '0;
        if (r < 18) return DT_W'($urandom);
        case ($urandom_range(0, 3))
            0: return DT_W'(1);
            1: return '1;
            2: return DT_W'(32'h1_0000);
            default: return DT_W'(32'h8_0000);
        endcase
    endfunction

    initial begin
        int phase;
        int item;
        int waited;
        osc_model = new();
        src_gaps = 1'b1;
        snk_gaps = 1'b1;
        long_hold_req = 1'b0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_STIFFNESS;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_time_step = '0;
        s_restart = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // --- directed part ---
        // Reset coefficients are all zero: the state must stay put.
        send_step(DT_W'(32'h1_0000), 1'b0);
        send_step('1, 1'b1);
        drain_steps();

        // Lightly damped spring: a = -1.0, b = -0.125, start x = 1.0, v = 0.5.
        set_coefs(32'hFFFF_0000, 32'hFFFF_E000, 32'h0, 32'h0001_0000, 32'h0000_8000);
        send_step(DT_W'(32'h1000), 1'b1);
        send_step(DT_W'(32'h1000), 1'b0);
        send_step('0, 1'b0);                     // zero step keeps state
        send_step(DT_W'(1), 1'b0);               // smallest nonzero step
        send_step('1, 1'b0);                     // longest step
        send_step(DT_W'(32'h1_0000), 1'b1);
        drain_steps();

        // Writes past the last register must leave every setting alone.
        for (int i = CFG_START_VEL + 1; i < (1 << CFG_IDX_W); i++)
            cfg_write(CFG_IDX_W'(i), 32'h7FFF_FFFF);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        send_step(DT_W'(32'h1000), 1'b0);
        drain_steps();

        // Saturation toward the top of the range.
        set_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_step('1, 1'b1);
        send_step('1, 1'b0);
        send_step(DT_W'(32'h8000), 1'b0);
        drain_steps();

        // Saturation toward the bottom, mixed signs.
        set_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_step('1, 1'b1);
        send_step(DT_W'(1), 1'b0);
        send_step('0, 1'b1);
        drain_steps();

        set_coefs(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h8000_0000, 32'h8000_0000);
        send_step(DT_W'(32'h1_0000), 1'b1);
        drain_steps();

        // --- random part: new settings per phase, then a run of steps ---
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            // last phases run without gaps or stalls
            if (phase >= RAND_PHASES - 4) begin
                src_gaps = 1'b0;
                snk_gaps = 1'b0;
            end
            if ($urandom_range(0, 3) == 0)
                cfg_write(CFG_IDX_W'($urandom_range(CFG_START_VEL + 1, (1 << CFG_IDX_W) - 1)),
                          $urandom);
            set_coefs(pick_value(32'h4_0000), pick_value(32'h1_0000), pick_value(32'h4_0000),
                      pick_value(32'h10_0000), pick_value(32'h10_0000));
            // one phase with the receiver parked while steps keep coming
            if (phase == 5)
                long_hold_req = 1'b1;
            for (item = 0; item < PHASE_ITEMS; item++)
                send_step(pick_step(), (item == 0) || ($urandom_range(0, 99) < 8));
            drain_steps();
        end

        // --- wrap-up ---
        waited = 0;
        while (osc_model.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (osc_model.clean())
            $display("** rk4_linear_oscillator_step_top: PASSED **");
        else
            $display("** rk4_linear_oscillator_step_top: FAILED **");
        $finish;
    end

endmodule
